[sv/smbs_pkg.sv]
// Shared types and constants for the SPI master byte shifter.
// No dependencies; imported by every module of the block except the checker.
`timescale 1ns / 1ps

package smbs_pkg;

  // operation codes carried on s_tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_HALF_PERIOD    = 2'd0;
  localparam logic [1:0] REG_CLOCK_POLARITY = 2'd1;
  localparam logic [1:0] REG_CLOCK_PHASE    = 2'd2;
  localparam logic [1:0] REG_LSB_FIRST      = 2'd3;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd80;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // live configuration seen by the shifter core
  typedef struct packed {
    logic [15:0] half_period;
    logic        clock_polarity;
    logic        clock_phase;
    logic        lsb_first;
    logic        polarity_write;  // polarity register written this cycle
  } cfg_t;

  // one result word, state after the item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       select_level;
    logic       mosi_level;
    logic       sclk_level;
  } result_t;

endpackage

[sv/smbs_cfg_regs.sv]
// Configuration register file with APB-style access.
// Depends on smbs_pkg for register indexes and cfg_t.
`timescale 1ns / 1ps

module smbs_cfg_regs
  import smbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [15:0] half_period;
  logic        clock_polarity;
  logic        clock_phase;
  logic        lsb_first;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period    <= HALF_PERIOD_RESET;
      clock_polarity <= 1'b0;
      clock_phase    <= 1'b0;
      lsb_first      <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HALF_PERIOD:    half_period    <= pwdata[15:0];
        REG_CLOCK_POLARITY: clock_polarity <= pwdata[0];
        REG_CLOCK_PHASE:    clock_phase    <= pwdata[0];
        REG_LSB_FIRST:      lsb_first      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_HALF_PERIOD:    prdata = {16'd0, half_period};
      REG_CLOCK_POLARITY: prdata = {31'd0, clock_polarity};
      REG_CLOCK_PHASE:    prdata = {31'd0, clock_phase};
      REG_LSB_FIRST:      prdata = {31'd0, lsb_first};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg.half_period    = half_period;
  assign cfg.clock_polarity = clock_polarity;
  assign cfg.clock_phase    = clock_phase;
  assign cfg.lsb_first      = lsb_first;
  // the core moves the idle clock level in the following cycle, once the register holds it
  assign cfg.polarity_write = wr_en && (reg_idx == REG_CLOCK_POLARITY);

endmodule

[sv/smbs_core.sv]
// Shifter core: divider, half-step counter, tx/rx shift registers and pins.
// Depends on smbs_pkg; computes one result word per accepted item.
`timescale 1ns / 1ps

module smbs_core
  import smbs_pkg::*;
#(
  parameter int HALF_STEPS = 17
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_en,
  input  logic       operation,
  input  logic [7:0] tx_byte,
  input  logic       miso_level,
  input  cfg_t       cfg,
  output result_t    res
);

  localparam int STEP_W = $clog2(HALF_STEPS + 1);

  logic [15:0]       tick_count, tick_count_next;
  logic [STEP_W-1:0] half_step, half_step_next;
  logic [7:0]        tx_shift, tx_shift_next;
  logic [7:0]        rx_shift, rx_shift_next;
  logic              sclk_reg, sclk_reg_next;
  logic              mosi_reg, mosi_reg_next;
  logic              busy_reg, busy_reg_next;
  logic              done;

  logic [STEP_W-1:0] k;
  logic              odd, step, do_drive, do_sample, last;
  logic              pol_pending;
  logic              sclk_base;

  assign k    = half_step + STEP_W'(1);
  assign odd  = k[0];
  assign last = (k >= STEP_W'(HALF_STEPS));
  assign step = (operation == OP_TICK) && busy_reg && (tick_count >= cfg.half_period);

  // idle clock level already follows a polarity written in the previous cycle
  assign sclk_base = (pol_pending && !busy_reg) ? cfg.clock_polarity : sclk_reg;

  // phase 0 drives on odd half-steps; phase 1 drives on even, samples odd from the third
  assign do_drive  = cfg.clock_phase ? !odd : odd;
  assign do_sample = cfg.clock_phase ? (odd && (half_step != '0)) : !odd;

  // next state for one item
  always_comb begin
    tick_count_next = tick_count;
    half_step_next  = half_step;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    sclk_reg_next   = sclk_base;
    mosi_reg_next   = mosi_reg;
    busy_reg_next   = busy_reg;
    done            = 1'b0;
    if (operation == OP_START) begin
      if (!busy_reg) begin
        tx_shift_next   = tx_byte;
        rx_shift_next   = 8'd0;
        tick_count_next = 16'd0;
        half_step_next  = '0;
        busy_reg_next   = 1'b1;
        sclk_reg_next   = cfg.clock_polarity;
      end
    end else if (busy_reg) begin
      if (step) begin
        tick_count_next = 16'd0;
        if (do_drive) begin
          if (cfg.lsb_first) begin
            mosi_reg_next = tx_shift[0];
            tx_shift_next = {1'b0, tx_shift[7:1]};
          end else begin
            mosi_reg_next = tx_shift[7];
            tx_shift_next = {tx_shift[6:0], 1'b0};
          end
        end
        if (do_sample) begin
          if (cfg.lsb_first) begin
            rx_shift_next = {miso_level, rx_shift[7:1]};
          end else begin
            rx_shift_next = {rx_shift[6:0], miso_level};
          end
        end
        sclk_reg_next = odd ? cfg.clock_polarity : ~cfg.clock_polarity;
        if (last) begin
          half_step_next = '0;
          busy_reg_next  = 1'b0;
          done           = 1'b1;
        end else begin
          half_step_next = k;
        end
      end else begin
        tick_count_next = tick_count + 16'd1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= 16'd0;
      half_step   <= '0;
      tx_shift    <= 8'd0;
      rx_shift    <= 8'd0;
      sclk_reg    <= 1'b0;
      mosi_reg    <= 1'b0;
      busy_reg    <= 1'b0;
      pol_pending <= 1'b0;
    end else begin
      pol_pending <= cfg.polarity_write;
      if (item_en) begin
        tick_count <= tick_count_next;
        half_step  <= half_step_next;
        tx_shift   <= tx_shift_next;
        rx_shift   <= rx_shift_next;
        sclk_reg   <= sclk_reg_next;
        mosi_reg   <= mosi_reg_next;
        busy_reg   <= busy_reg_next;
      end else if (pol_pending && !busy_reg) begin
        // idle clock follows a new polarity
        sclk_reg <= cfg.clock_polarity;
      end
    end
  end

  // result word, state after the item
  assign res.sclk_level   = sclk_reg_next;
  assign res.mosi_level   = mosi_reg_next;
  assign res.select_level = busy_reg_next;
  assign res.busy_res     = busy_reg_next;
  assign res.done_res     = done;
  assign res.rx_byte      = done ? rx_shift_next : 8'd0;

endmodule

[sv/smbs_out_reg.sv]
// Output register stage on the master side of the stream.
// Depends on smbs_pkg for result_t; gives the input ready back to the top level.
`timescale 1ns / 1ps

module smbs_out_reg
  import smbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  result_t               res,
  output logic                  room,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // sclk, mosi, select, busy, rx_byte[7:0], zero pad
  output logic                  m_tuser    // done_res
);

  result_t held;

  // a new word may enter when the stage is empty or being drained
  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {4'd0, held.rx_byte, held.busy_res, held.select_level,
                    held.mosi_level, held.sclk_level};
  assign m_tuser = held.done_res;

endmodule

[sv/spi_master_byte_shifter.sv]
// SPI master byte shifter, modes 0 to 3, one byte per transfer.
// An accepted word's result is registered and shows on the master side in the next cycle.
// Throughput: one word per cycle unless m_tready stalls the single output register stage.
// A transfer spans 17 half-steps of half_period+1 tick words each.
// Reset (rst, synchronous, active high) clears the shifter state, sets the
// registers to their defaults and empties the output stage.
`timescale 1ns / 1ps

module spi_master_byte_shifter
  import smbs_pkg::*;
#(
  parameter int HALF_STEPS = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // tx_byte[7:0], miso_level, zero pad
  input  logic                  s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // sclk, mosi, select, busy, rx_byte[7:0], zero pad
  output logic                  m_tuser,   // done_res
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t res;
  logic    accept;
  logic    room;

  assign s_tready = room;
  assign accept   = s_tvalid && room;

  smbs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smbs_core #(
    .HALF_STEPS (HALF_STEPS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_en    (accept),
    .operation  (s_tuser),
    .tx_byte    (s_tdata[7:0]),
    .miso_level (s_tdata[8]),
    .cfg        (cfg),
    .res        (res)
  );

  smbs_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res      (res),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[sv/smbs_checker.sv]
// Port-level checks for the SPI master byte shifter, bound to the top level.
// Depends only on the top level's master-side ports.
`timescale 1ns / 1ps

module smbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // output stage is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // done ends the transfer
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[3] && !m_tdata[2])
    else $error("done shown while still busy");

  // received byte shows only with done
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[11:4] == 8'd0)
    else $error("received byte shown without done");

  // chip select tracks busy
  a_select_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2] == m_tdata[3])
    else $error("chip select differs from busy");

endmodule

bind spi_master_byte_shifter smbs_checker u_smbs_checker (.*);
